FILE: rtl/wpsb_pkg.sv
`default_nettype none

package wpsb_pkg;

    // fraction bits of all fixed-point values
    localparam int FRAC_BITS_DEF = 16;

    // configuration register indexes
    localparam logic [2:0] REG_ROW0_XY = 3'd0;
    localparam logic [2:0] REG_ROW0_ZW = 3'd1;
    localparam logic [2:0] REG_ROW1_XY = 3'd2;
    localparam logic [2:0] REG_ROW1_ZW = 3'd3;
    localparam logic [2:0] REG_ROW3_XY = 3'd4;
    localparam logic [2:0] REG_ROW3_ZW = 3'd5;
    localparam logic [2:0] REG_SCREEN  = 3'd6;
    localparam logic [2:0] REG_TEAM    = 3'd7;

    // screen size after reset: 1920 x 1080
    localparam logic [31:0] SCREEN_RESET = 32'd70780800;

    // result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_INELIGIBLE = 3'd1;
    localparam logic [2:0] ST_FEET_BEHIND = 3'd2;
    localparam logic [2:0] ST_HEAD_BEHIND = 3'd3;
    localparam logic [2:0] ST_TOO_SMALL  = 3'd4;

    // per-word control that rides along the pipeline
    typedef struct packed {
        logic       team_match;
        logic [5:0] tag;
        logic       elig;
    } ctl_t;

    // control that rides alongside the dividers
    typedef struct packed {
        ctl_t       ctl;
        logic [1:0] wok;   // index: point (0 feet, 1 head)
        logic [3:0] neg;   // index: point * 2 + axis
    } div_side_t;

    // clamp a signed value to the 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/wpsb_div.sv
`default_nettype none

// pipelined restoring divider, one quotient bit per stage
module wpsb_div #(
    parameter int N  = 48,
    parameter int DW = 32
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [N-1:0]  num,
    input  wire logic [DW-1:0] den,
    output logic      [N-1:0]  quo
);

    logic [DW-1:0] rem_reg [0:N];
    logic [N-1:0]  nq_reg  [0:N];
    logic [DW-1:0] den_reg [0:N];

    logic [DW:0]   rem_sh  [0:N-1];
    logic [DW:0]   diff    [0:N-1];

    // trial subtract for every stage
    always_comb begin
        for (int k = 0; k < N; k++) begin
            rem_sh[k] = {rem_reg[k], nq_reg[k][N-1]};
            diff[k]   = rem_sh[k] - {1'b0, den_reg[k]};
        end
    end

    // stage registers: numerator bits shift out the top, quotient bits in the bottom
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= '0;
            nq_reg[0]  <= num;
            den_reg[0] <= den;
            for (int k = 0; k < N; k++) begin
                if (!diff[k][DW]) begin
                    rem_reg[k+1] <= diff[k][DW-1:0];
                end else begin
                    rem_reg[k+1] <= rem_sh[k][DW-1:0];
                end
                nq_reg[k+1]  <= {nq_reg[k][N-2:0], ~diff[k][DW]};
                den_reg[k+1] <= den_reg[k];
            end
        end
    end

    assign quo = nq_reg[N];

endmodule

`default_nettype wire

FILE: rtl/world_points_to_screen_box_core.sv
`default_nettype none

// channel  | handshake           | payload
// s_       | s_valid / s_ready   | feet and head points, team, flags, tag
// m_       | m_valid / m_ready   | status, box edges and size, color flag, tag
// cfg_     | cfg_we              | cfg_idx, cfg_wdata (write only)
//
// one word enters per cycle while the pipe is not frozen; the path runs through
// the four bit-per-stage dividers (32 + FRAC_BITS + 1 stages)
// plus nine arithmetic stages around them.
// reset clears the valid bits and loads the config registers with their reset values; no clearing pass.
// a full output register with m_ready low freezes every stage at once.
module world_points_to_screen_box_core #(
    parameter int FRAC_BITS = wpsb_pkg::FRAC_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_idx,
    input  wire logic [63:0]        cfg_wdata,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_feet_x,
    input  wire logic signed [31:0] s_feet_y,
    input  wire logic signed [31:0] s_feet_z,
    input  wire logic signed [31:0] s_head_x,
    input  wire logic signed [31:0] s_head_y,
    input  wire logic signed [31:0] s_head_z,
    input  wire logic [7:0]         s_entity_team,
    input  wire logic               s_entity_alive,
    input  wire logic               s_entity_has_node,
    input  wire logic [5:0]         s_entity_tag,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [2:0]              m_status,
    output logic signed [31:0]      m_box_left,
    output logic signed [31:0]      m_box_top,
    output logic [30:0]             m_box_width,
    output logic [30:0]             m_box_height,
    output logic                    m_use_team_color,
    output logic [5:0]              m_tag_out
);

    localparam int NW = 32 + FRAC_BITS;
    localparam logic signed [31:0] W_MIN =
        32'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic signed [31:0] WRATIO =
        32'(((64'd45 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic signed [32:0] MIN_H = 33'(64'd5 << FRAC_BITS);
    localparam logic signed [32:0] ONE   = 33'(64'd1 << FRAC_BITS);
    localparam logic [NW-1:0] QMAX_POS = NW'(64'h7fffffff);
    localparam logic [NW-1:0] QMAX_NEG = NW'(64'h80000000);

    logic en;

    // configuration registers: rows 0, 1, 3 as [row][col]
    logic signed [31:0] mtx_reg [3][4];
    logic [31:0]        screen_reg;
    logic [8:0]         team_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 4; c++) begin
                    mtx_reg[r][c] <= '0;
                end
            end
            screen_reg <= wpsb_pkg::SCREEN_RESET;
            team_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_idx)
                wpsb_pkg::REG_ROW0_XY: begin
                    mtx_reg[0][0] <= cfg_wdata[31:0];
                    mtx_reg[0][1] <= cfg_wdata[63:32];
                end
                wpsb_pkg::REG_ROW0_ZW: begin
                    mtx_reg[0][2] <= cfg_wdata[31:0];
                    mtx_reg[0][3] <= cfg_wdata[63:32];
                end
                wpsb_pkg::REG_ROW1_XY: begin
                    mtx_reg[1][0] <= cfg_wdata[31:0];
                    mtx_reg[1][1] <= cfg_wdata[63:32];
                end
                wpsb_pkg::REG_ROW1_ZW: begin
                    mtx_reg[1][2] <= cfg_wdata[31:0];
                    mtx_reg[1][3] <= cfg_wdata[63:32];
                end
                wpsb_pkg::REG_ROW3_XY: begin
                    mtx_reg[2][0] <= cfg_wdata[31:0];
                    mtx_reg[2][1] <= cfg_wdata[63:32];
                end
                wpsb_pkg::REG_ROW3_ZW: begin
                    mtx_reg[2][2] <= cfg_wdata[31:0];
                    mtx_reg[2][3] <= cfg_wdata[63:32];
                end
                wpsb_pkg::REG_SCREEN: screen_reg <= cfg_wdata[31:0];
                wpsb_pkg::REG_TEAM:   team_reg   <= cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    // whole pipe moves when the output register is free or being taken
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // stage 1: matrix products, [point][row][col]
    logic signed [31:0] pt [2][3];
    logic signed [63:0] prod1_reg [2][3][3];
    logic               v1_reg;
    wpsb_pkg::ctl_t     ctl1_reg;

    always_comb begin
        pt[0][0] = s_feet_x;
        pt[0][1] = s_feet_y;
        pt[0][2] = s_feet_z;
        pt[1][0] = s_head_x;
        pt[1][1] = s_head_y;
        pt[1][2] = s_head_z;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int p = 0; p < 2; p++) begin
                for (int r = 0; r < 3; r++) begin
                    for (int c = 0; c < 3; c++) begin
                        prod1_reg[p][r][c] <= 64'(pt[p][c]) * 64'(mtx_reg[r][c]);
                    end
                end
            end
            ctl1_reg.team_match <= team_reg[8] && (team_reg[7:0] == s_entity_team);
            ctl1_reg.tag        <= s_entity_tag;
            ctl1_reg.elig       <= s_entity_alive && s_entity_has_node;
        end
    end

    // stage 2: floor-shifted products plus constant column
    logic signed [65:0] sum2_reg [2][3];
    logic               v2_reg;
    wpsb_pkg::ctl_t     ctl2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int p = 0; p < 2; p++) begin
                for (int r = 0; r < 3; r++) begin
                    sum2_reg[p][r] <= 66'(prod1_reg[p][r][0] >>> FRAC_BITS)
                                    + 66'(prod1_reg[p][r][1] >>> FRAC_BITS)
                                    + 66'(prod1_reg[p][r][2] >>> FRAC_BITS)
                                    + 66'(mtx_reg[r][3]);
                end
            end
            ctl2_reg <= ctl1_reg;
        end
    end

    // stage 3: clip values
    logic signed [31:0] clip3_reg [2][3];
    logic               v3_reg;
    wpsb_pkg::ctl_t     ctl3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int p = 0; p < 2; p++) begin
                for (int r = 0; r < 3; r++) begin
                    clip3_reg[p][r] <= wpsb_pkg::sat32(sum2_reg[p][r]);
                end
            end
            ctl3_reg <= ctl2_reg;
        end
    end

    // divider operands: magnitude of clip x/y scaled up, over clip w
    logic [NW-1:0]        div_num [4];
    logic [31:0]          div_den [4];
    logic [NW-1:0]        div_quo [4];
    logic signed [32:0]   clip_ext [4];
    wpsb_pkg::div_side_t  side_in;

    always_comb begin
        side_in.ctl = ctl3_reg;
        for (int p = 0; p < 2; p++) begin
            side_in.wok[p] = clip3_reg[p][2] > W_MIN;
            for (int a = 0; a < 2; a++) begin
                clip_ext[p*2+a]    = 33'(clip3_reg[p][a]);
                side_in.neg[p*2+a] = clip3_reg[p][a][31];
                div_num[p*2+a] = {(side_in.neg[p*2+a] ? 32'(-clip_ext[p*2+a])
                                                      : 32'(clip_ext[p*2+a])),
                                  {FRAC_BITS{1'b0}}};
                div_den[p*2+a] = clip3_reg[p][2];
            end
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_div
        wpsb_div #(
            .N  (NW),
            .DW (32)
        ) u_div (
            .aclk (aclk),
            .en   (en),
            .num  (div_num[g]),
            .den  (div_den[g]),
            .quo  (div_quo[g])
        );
    end

    // side data and valid bits matched to the divider latency
    wpsb_pkg::div_side_t side_reg [0:NW];
    logic                vd_reg   [0:NW];

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_in;
            for (int k = 0; k < NW; k++) begin
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    // stage 4: signed, saturated ndc turned into 1 + x and 1 - y
    logic signed [31:0] ndc [4];
    logic signed [32:0] t4_reg [4];
    logic               v4_reg;
    wpsb_pkg::div_side_t side4_reg;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (side_reg[NW].neg[i]) begin
                if (div_quo[i] > QMAX_NEG) begin
                    ndc[i] = 32'sh80000000;
                end else begin
                    ndc[i] = 32'(-div_quo[i]);
                end
            end else begin
                if (div_quo[i] > QMAX_POS) begin
                    ndc[i] = 32'sh7fffffff;
                end else begin
                    ndc[i] = 32'(div_quo[i]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int p = 0; p < 2; p++) begin
                t4_reg[p*2]   <= 33'(ndc[p*2]) + ONE;
                t4_reg[p*2+1] <= ONE - 33'(ndc[p*2+1]);
            end
            side4_reg <= side_reg[NW];
        end
    end

    // stage 5: scale by screen width / height
    logic signed [49:0] prod5_reg [4];
    logic               v5_reg;
    wpsb_pkg::div_side_t side5_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int p = 0; p < 2; p++) begin
                prod5_reg[p*2]   <= 50'(t4_reg[p*2])
                                  * 50'($signed({1'b0, screen_reg[15:0]}));
                prod5_reg[p*2+1] <= 50'(t4_reg[p*2+1])
                                  * 50'($signed({1'b0, screen_reg[31:16]}));
            end
            side5_reg <= side4_reg;
        end
    end

    // stage 6: halve and saturate screen coordinates
    logic signed [31:0] scr6_reg [4];
    logic               v6_reg;
    wpsb_pkg::div_side_t side6_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                scr6_reg[i] <= wpsb_pkg::sat32(66'(prod5_reg[i] >>> 1));
            end
            side6_reg <= side5_reg;
        end
    end

    // stage 7: box height and status
    logic signed [31:0] bh_s;
    logic signed [31:0] bh7_reg;
    logic signed [31:0] hx7_reg;
    logic signed [31:0] hy7_reg;
    logic [2:0]         st7_reg;
    wpsb_pkg::ctl_t     ctl7_reg;
    logic               v7_reg;

    assign bh_s = wpsb_pkg::sat32(66'(33'(scr6_reg[1]) - 33'(scr6_reg[3])));

    always_ff @(posedge aclk) begin
        if (en) begin
            bh7_reg  <= bh_s;
            hx7_reg  <= scr6_reg[2];
            hy7_reg  <= scr6_reg[3];
            ctl7_reg <= side6_reg.ctl;
            if (!side6_reg.ctl.elig) begin
                st7_reg <= wpsb_pkg::ST_INELIGIBLE;
            end else if (!side6_reg.wok[0]) begin
                st7_reg <= wpsb_pkg::ST_FEET_BEHIND;
            end else if (!side6_reg.wok[1]) begin
                st7_reg <= wpsb_pkg::ST_HEAD_BEHIND;
            end else if (33'(bh_s) < MIN_H) begin
                st7_reg <= wpsb_pkg::ST_TOO_SMALL;
            end else begin
                st7_reg <= wpsb_pkg::ST_OK;
            end
        end
    end

    // stage 8: width product
    logic signed [63:0] bwp8_reg;
    logic signed [31:0] bh8_reg;
    logic signed [31:0] hx8_reg;
    logic signed [31:0] hy8_reg;
    logic [2:0]         st8_reg;
    wpsb_pkg::ctl_t     ctl8_reg;
    logic               v8_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            bwp8_reg <= 64'(bh7_reg) * 64'(WRATIO);
            bh8_reg  <= bh7_reg;
            hx8_reg  <= hx7_reg;
            hy8_reg  <= hy7_reg;
            st8_reg  <= st7_reg;
            ctl8_reg <= ctl7_reg;
        end
    end

    // output register: width, left edge, masking of failed boxes
    logic signed [63:0] bw_s;
    logic signed [31:0] left_s;
    logic               m_valid_reg;
    logic [2:0]         status_reg;
    logic signed [31:0] left_reg;
    logic signed [31:0] top_reg;
    logic [30:0]        width_reg;
    logic [30:0]        height_reg;
    logic               color_reg;
    logic [5:0]         tag_reg;

    assign bw_s   = bwp8_reg >>> FRAC_BITS;
    assign left_s = wpsb_pkg::sat32(66'(hx8_reg) - 66'(bw_s >>> 1));

    always_ff @(posedge aclk) begin
        if (en) begin
            status_reg <= st8_reg;
            color_reg  <= ctl8_reg.team_match;
            tag_reg    <= ctl8_reg.tag;
            if (st8_reg == wpsb_pkg::ST_OK) begin
                left_reg   <= left_s;
                top_reg    <= hy8_reg;
                width_reg  <= bw_s[30:0];
                height_reg <= bh8_reg[30:0];
            end else begin
                left_reg   <= '0;
                top_reg    <= '0;
                width_reg  <= '0;
                height_reg <= '0;
            end
        end
    end

    // valid bits, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            for (int k = 0; k <= NW; k++) begin
                vd_reg[k] <= 1'b0;
            end
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            v7_reg      <= 1'b0;
            v8_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg    <= s_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            vd_reg[0] <= v3_reg;
            for (int k = 0; k < NW; k++) begin
                vd_reg[k+1] <= vd_reg[k];
            end
            v4_reg      <= vd_reg[NW];
            v5_reg      <= v4_reg;
            v6_reg      <= v5_reg;
            v7_reg      <= v6_reg;
            v8_reg      <= v7_reg;
            m_valid_reg <= v8_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = status_reg;
    assign m_box_left       = left_reg;
    assign m_box_top        = top_reg;
    assign m_box_width      = width_reg;
    assign m_box_height     = height_reg;
    assign m_use_team_color = color_reg;
    assign m_tag_out        = tag_reg;

endmodule

`default_nettype wire
